// File: hw/rtl/cte_pkg.sv
// shared types and constants for the charstring token encoder
package cte_pkg;

   // default sizes
   localparam int MASK_BITS_DEFAULT   = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // body byte count field, wide enough for a full 64-bit hint mask
   localparam int CNT_W = 4;

   // token kinds carried on the request channel
   typedef enum logic [1:0] {
      MODE_OPERAND   = 2'd0,
      MODE_OPERATOR  = 2'd1,
      MODE_HINT_MASK = 2'd2
   } mode_type;

   // operand range limits
   localparam logic signed [31:0] OPND_SMALL_MAX = 32'sd107;
   localparam logic signed [31:0] OPND_SMALL_MIN = -32'sd107;
   localparam logic signed [31:0] OPND_SHORT_LO  = 32'sd108;
   localparam logic signed [31:0] OPND_SHORT_HI  = 32'sd1131;
   localparam logic signed [31:0] OPND_NSHORT_LO = -32'sd1131;
   localparam logic signed [31:0] OPND_NSHORT_HI = -32'sd108;
   localparam logic signed [31:0] OPND_INT16_MIN = -32'sd32768;
   localparam logic signed [31:0] OPND_INT16_MAX = 32'sd32767;

   // encoding bytes
   localparam logic [7:0]  BYTE_BIAS     = 8'd139;
   localparam logic [7:0]  LEAD_POS      = 8'd247;
   localparam logic [7:0]  LEAD_NEG      = 8'd251;
   localparam logic [7:0]  LEAD_SHORTINT = 8'd28;
   localparam logic [7:0]  OP_ESCAPE     = 8'd12;
   localparam logic [7:0]  OP_HINTMASK   = 8'd19;
   localparam logic [15:0] SHORT_BIAS    = 16'd108;
   localparam logic [15:0] SHORT_BIAS_M1 = 16'd107;

   // control part of one classified token
   typedef struct packed {
      logic             range_error;
      logic [7:0]       header;
      logic [CNT_W-1:0] body_bytes;
   } token_ctl_type;

endpackage

// File: hw/rtl/charstring_token_encoder_core.sv
// top level of the charstring token encoder: front end, token queue, back end
// a request's first response byte passes through the queue, then the output register
// throughput: one response byte per cycle while rsp_stall is low; a token's run holds
//   1 to 3 bytes for operands and operators, 2 to 1+ceil(MASK_BITS/8) for hint masks
// the back end's one-byte-per-cycle output register sets the rate; the queue lets
//   requests be taken while a long run is still being played out
// reset (synchronous, active high) empties the queue and drops any partly sent run
module charstring_token_encoder_core
   import cte_pkg::*;
#(
   parameter int MASK_BITS   = MASK_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_operand_value,
   input  logic [15:0]        req_operator_code,
   input  logic [63:0]        req_mask_bits,
   input  logic [6:0]         req_hint_count,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_range_error
);

   // body must hold the whole mask, and at least the two bytes of a 16-bit operand
   localparam int MASK_BYTES = (MASK_BITS + 7) / 8;
   localparam int BODY_BYTES = (MASK_BYTES > 2) ? MASK_BYTES : 2;
   localparam int BODY_W     = BODY_BYTES * 8;
   localparam int ENTRY_W    = $bits(token_ctl_type) + BODY_W;

   // front end to queue
   logic               q_full;
   logic               q_push;
   token_ctl_type      push_ctl;
   logic [BODY_W-1:0]  push_body;

   // queue to back end
   logic               q_not_empty;
   logic               q_pop;
   logic [ENTRY_W-1:0] pop_data;
   token_ctl_type      pop_ctl;
   logic [BODY_W-1:0]  pop_body;

   // classify the request into header byte, body bytes and error flag
   cte_front #(
      .MASK_BITS  (MASK_BITS),
      .BODY_BYTES (BODY_BYTES)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_operand_value (req_operand_value),
      .req_operator_code (req_operator_code),
      .req_mask_bits     (req_mask_bits),
      .req_hint_count    (req_hint_count),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_ctl             (push_ctl),
      .q_body            (push_body)
   );

   // decouples request intake from byte play-out
   cte_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_ctl, push_body}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   assign pop_ctl  = token_ctl_type'(pop_data[ENTRY_W-1:BODY_W]);
   assign pop_body = pop_data[BODY_W-1:0];

   // header first, then body bytes most significant first
   cte_back #(
      .BODY_BYTES (BODY_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_not_empty),
      .q_ctl           (pop_ctl),
      .q_body          (pop_body),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// File: hw/rtl/cte_front.sv
// front end: takes requests and turns each into a header byte plus body bytes
module cte_front
   import cte_pkg::*;
#(
   parameter int MASK_BITS  = MASK_BITS_DEFAULT,
   parameter int BODY_BYTES = 8
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic signed [31:0]          req_operand_value,
   input  logic [15:0]                 req_operator_code,
   input  logic [63:0]                 req_mask_bits,
   input  logic [6:0]                  req_hint_count,
   input  logic                        q_full,
   output logic                        q_push,
   output token_ctl_type               q_ctl,
   output logic [BODY_BYTES*8-1:0]     q_body
);

   localparam logic [6:0] MASK_BITS_W = 7'(MASK_BITS);

   logic        keep;
   logic [15:0] op16;
   logic [15:0] pos_v;
   logic [15:0] neg_v;
   logic [6:0]  cnt_sat;
   logic [6:0]  cnt_round;
   logic [CNT_W-1:0] nbytes;

   assign op16      = req_operand_value[15:0];
   assign pos_v     = op16 - SHORT_BIAS;
   // -(v + 108) == ~v - 107
   assign neg_v     = ~op16 - SHORT_BIAS_M1;
   assign cnt_sat   = (req_hint_count > MASK_BITS_W) ? MASK_BITS_W : req_hint_count;
   assign cnt_round = cnt_sat + 7'd7;

   always_comb begin
      nbytes = CNT_W'(cnt_round[6:3]);
      if (nbytes == '0) begin
         nbytes = CNT_W'(1);
      end
   end

   always_comb begin
      keep   = 1'b1;
      q_ctl  = '0;
      q_body = '0;
      case (mode_type'(req_mode))
         MODE_OPERAND: begin
            if (req_operand_value >= OPND_SMALL_MIN && req_operand_value <= OPND_SMALL_MAX) begin
               q_ctl.header = op16[7:0] + BYTE_BIAS;
            end else if (req_operand_value >= OPND_SHORT_LO &&
                         req_operand_value <= OPND_SHORT_HI) begin
               q_ctl.header     = LEAD_POS + {6'd0, pos_v[9:8]};
               q_body[7:0]      = pos_v[7:0];
               q_ctl.body_bytes = CNT_W'(1);
            end else if (req_operand_value >= OPND_NSHORT_LO &&
                         req_operand_value <= OPND_NSHORT_HI) begin
               q_ctl.header     = LEAD_NEG + {6'd0, neg_v[9:8]};
               q_body[7:0]      = neg_v[7:0];
               q_ctl.body_bytes = CNT_W'(1);
            end else if (req_operand_value >= OPND_INT16_MIN &&
                         req_operand_value <= OPND_INT16_MAX) begin
               q_ctl.header     = LEAD_SHORTINT;
               q_body[15:0]     = op16;
               q_ctl.body_bytes = CNT_W'(2);
            end else begin
               q_ctl.range_error = 1'b1;
            end
         end
         MODE_OPERATOR: begin
            if (req_operator_code[15:8] == OP_ESCAPE) begin
               q_ctl.header     = OP_ESCAPE;
               q_body[7:0]      = req_operator_code[7:0];
               q_ctl.body_bytes = CNT_W'(1);
            end else begin
               q_ctl.header = req_operator_code[7:0];
            end
         end
         MODE_HINT_MASK: begin
            q_ctl.header              = OP_HINTMASK;
            q_body[MASK_BITS-1:0]     = req_mask_bits[MASK_BITS-1:0];
            q_ctl.body_bytes          = nbytes;
         end
         default: begin
            // unused mode: taken and dropped
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

// File: hw/rtl/cte_queue.sv
// small register queue between the front and back ends
module cte_queue
   import cte_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_QW-1:0] DEPTH_CNT = CNT_QW'(DEPTH);

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue occupancy beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_QW'(1)))
      else $error("queue occupancy did not grow on push");

endmodule

// File: hw/rtl/cte_back.sv
// back end: plays out one token as a run of response bytes
module cte_back
   import cte_pkg::*;
#(
   parameter int BODY_BYTES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  token_ctl_type           q_ctl,
   input  logic [BODY_BYTES*8-1:0] q_body,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last,
   output logic                    rsp_range_error
);

   localparam int IDX_W = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;

   typedef enum logic {
      ST_HEAD,
      ST_BODY
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [BODY_BYTES-1:0][7:0]  body_ff, body_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        err_ff, err_in;
   logic                        load_ok;
   logic [CNT_W-1:0]            rem_less;
   logic [IDX_W-1:0]            body_idx;

   assign load_ok  = !valid_ff || !rsp_stall;
   assign rem_less = rem_ff - CNT_W'(1);
   assign body_idx = rem_less[IDX_W-1:0];
   assign q_pop    = load_ok && (state_ff == ST_HEAD) && q_valid;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      body_in  = body_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (load_ok) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_HEAD: begin
            if (q_pop) begin
               valid_in = 1'b1;
               byte_in  = q_ctl.header;
               last_in  = (q_ctl.body_bytes == '0);
               err_in   = q_ctl.range_error;
               body_in  = q_body;
               rem_in   = q_ctl.body_bytes;
               if (q_ctl.body_bytes != '0) begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (load_ok) begin
               valid_in = 1'b1;
               byte_in  = body_ff[body_idx];
               last_in  = (rem_ff == CNT_W'(1));
               err_in   = 1'b0;
               rem_in   = rem_less;
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_HEAD;
               end
            end
         end
         default: begin
            state_in = ST_HEAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEAD;
         valid_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
      body_ff <= body_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && err_ff) |-> (last_ff && byte_ff == '0 && state_ff == ST_HEAD))
      else $error("range error response not a lone final byte");

   a_body_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY) |-> (rem_ff != '0))
      else $error("body state with no bytes left");

endmodule
